// ===== src/bpt_pkg.sv =====
// shared types and constants for the biquadratic patch tessellator
package bpt_pkg;

  localparam int VAL_W          = 32;
  localparam int GRID_W         = 7;
  localparam int SUB_W          = 7;
  localparam int IDX_W          = 13;
  localparam int NUM_CP         = 9;
  localparam int ADDR_W         = 3;
  localparam int DATA_W         = 32;
  localparam int MAX_SUBDIV_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [SUB_W-1:0] SUBDIV_RESET = 7'd8;
  // register index as seen in paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_SUBDIV  = 1'b0;

  typedef struct packed {
    logic [IDX_W-1:0] vertex_index;
    logic [IDX_W-1:0] strip_even_index;
    logic [IDX_W-1:0] strip_odd_index;
    logic             strip_valid;
    logic             range_error;
  } meta_t;

  typedef struct packed {
    logic [NUM_CP-1:0][VAL_W-1:0] cp;
    logic [GRID_W-1:0]            row;
    logic [GRID_W-1:0]            col;
    meta_t                        meta;
  } item_t;

endpackage

// ===== src/bpt_front.sv =====
// front end: range check, index computation and the item queue
module bpt_front import bpt_pkg::*; #(
  parameter int NW = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [NW-1:0]                n,
  input  logic                         push,
  output logic                         full,
  input  logic [NUM_CP-1:0][VAL_W-1:0] cp,
  input  logic [GRID_W-1:0]            row,
  input  logic [GRID_W-1:0]            col,
  input  logic                         q_pop,
  output logic                         q_empty,
  output item_t                        head
);

  localparam int QD  = 4;
  localparam int PW  = $clog2(QD);
  localparam int CW  = ((GRID_W > NW) ? GRID_W : NW) + 1;
  localparam int IW0 = GRID_W + NW + 2;
  localparam int IW  = (IW0 > IDX_W) ? IW0 : IDX_W;

  item_t          mem [QD];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           wr_en;
  logic           rd_en;
  item_t          item;
  logic [CW-1:0]  row_w;
  logic [CW-1:0]  col_w;
  logic [CW-1:0]  n_w;
  logic [IW-1:0]  n1;
  logic [IW-1:0]  vtx;
  logic [IW-1:0]  even;
  logic           err;
  logic           strip;

  assign row_w = CW'(row);
  assign col_w = CW'(col);
  assign n_w   = CW'(n);
  assign n1    = IW'(n) + IW'(1);
  assign vtx   = IW'(row) * n1 + IW'(col);
  assign even  = vtx + n1;
  assign err   = (row_w > n_w) || (col_w > n_w);
  assign strip = (row_w < n_w) && !err;

  always_comb begin
    item.cp                    = cp;
    item.row                   = row;
    item.col                   = col;
    item.meta.range_error      = err;
    item.meta.strip_valid      = strip;
    item.meta.vertex_index     = err ? '0 : vtx[IDX_W-1:0];
    item.meta.strip_even_index = strip ? even[IDX_W-1:0] : '0;
    item.meta.strip_odd_index  = strip ? vtx[IDX_W-1:0] : '0;
  end

  assign full    = (count == (PW+1)'(QD));
  assign q_empty = (count == '0);
  assign wr_en   = push && !full;
  assign rd_en   = q_pop && !q_empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/bpt_div.sv =====
// pipelined restoring divider: t = (k << FRAC_BITS) / n, one quotient bit per stage
module bpt_div import bpt_pkg::*; #(
  parameter int NW        = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NW-1:0]        n,
  input  logic [GRID_W-1:0]    k_u,
  input  logic [GRID_W-1:0]    k_v,
  output logic [FRAC_BITS:0]   t_u,
  output logic [FRAC_BITS:0]   t_v
);

  localparam int RW = ((GRID_W > NW) ? GRID_W : NW) + 1;
  localparam int TW = FRAC_BITS + 1;
  localparam int ST = FRAC_BITS + 1;

  logic [RW-1:0] r_u [ST];
  logic [RW-1:0] r_v [ST];
  logic [TW-1:0] q_u [ST];
  logic [TW-1:0] q_v [ST];
  logic [RW-1:0] d;

  assign d = RW'(n);

  // {quotient bit, remainder}
  function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic [RW-1:0] dv);
    logic bit_q;
    bit_q = (r >= dv);
    return {bit_q, bit_q ? (r - dv) : r};
  endfunction

  for (genvar j = 0; j < ST; j++) begin : g_stage
    logic [RW-1:0] ri_u;
    logic [RW-1:0] ri_v;
    logic [TW-1:0] qi_u;
    logic [TW-1:0] qi_v;
    logic [RW:0]   su;
    logic [RW:0]   sv;
    if (j == 0) begin : g_first
      assign ri_u = RW'(k_u);
      assign ri_v = RW'(k_v);
      assign qi_u = '0;
      assign qi_v = '0;
    end else begin : g_next
      assign ri_u = r_u[j-1];
      assign ri_v = r_v[j-1];
      assign qi_u = q_u[j-1];
      assign qi_v = q_v[j-1];
    end
    assign su = div_step(ri_u, d);
    assign sv = div_step(ri_v, d);
    always_ff @(posedge clk) begin
      if (en) begin
        r_u[j] <= {su[RW-2:0], 1'b0};
        r_v[j] <= {sv[RW-2:0], 1'b0};
        q_u[j] <= {qi_u[TW-2:0], su[RW]};
        q_v[j] <= {qi_v[TW-2:0], sv[RW]};
      end
    end
  end

  assign t_u = q_u[ST-1];
  assign t_v = q_v[ST-1];

endmodule

// ===== src/bpt_back.sv =====
// back end: parameter division, bernstein weights, two blend passes, result register
module bpt_back import bpt_pkg::*; #(
  parameter int NW        = 7,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [NW-1:0]       n,
  input  item_t               head,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [VAL_W-1:0]    value,
  output meta_t               meta
);

  localparam int TW = FRAC_BITS + 1;
  localparam int ST = FRAC_BITS + 1;
  localparam int PW = VAL_W + FRAC_BITS + 2;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] MAXV = {{(SW-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {{(SW-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  logic              en;
  logic              out_vld;
  logic [TW-1:0]     t_u;
  logic [TW-1:0]     t_v;

  item_t             dly [ST];
  logic              vld [ST];

  item_t             w_item;
  logic              w_vld;
  logic [3*TW-1:0]   wu;
  logic [3*TW-1:0]   wv;

  meta_t             m_meta;
  logic              m_vld;
  logic signed [PW-1:0] prod [NUM_CP];
  logic [3*TW-1:0]   m_wv;

  meta_t             a_meta;
  logic              a_vld;
  logic signed [VAL_W-1:0] tmp [3];
  logic [3*TW-1:0]   a_wv;

  meta_t             p_meta;
  logic              p_vld;
  logic signed [PW-1:0] prod2 [3];

  // whole pipeline freezes while a result waits unclaimed
  assign en    = !out_vld || pop;
  assign q_pop = en && !q_empty;
  assign empty = !out_vld;

  // {w0, w1, w2} for s = 1 - t
  function automatic logic [3*TW-1:0] weights(input logic [TW-1:0] t);
    logic [TW-1:0]   s;
    logic [2*TW-1:0] ss;
    logic [2*TW-1:0] ts;
    logic [2*TW-1:0] tt;
    s  = {1'b1, {FRAC_BITS{1'b0}}} - t;
    ss = (2*TW)'(s) * (2*TW)'(s);
    ts = (2*TW)'(t) * (2*TW)'(s);
    tt = (2*TW)'(t) * (2*TW)'(t);
    return {ss[2*FRAC_BITS:FRAC_BITS], ts[2*FRAC_BITS-1:FRAC_BITS-1],
            tt[2*FRAC_BITS:FRAC_BITS]};
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic [VAL_W-1:0] p,
                                               input logic [TW-1:0] w);
    return PW'($signed(p) * $signed({1'b0, w}));
  endfunction

  // floor shift of the exact sum, then saturate
  function automatic logic signed [VAL_W-1:0] blend_sum(input logic signed [PW-1:0] a,
                                                        input logic signed [PW-1:0] b,
                                                        input logic signed [PW-1:0] c);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] sh;
    s  = SW'(a) + SW'(b) + SW'(c);
    sh = s >>> FRAC_BITS;
    if (sh > MAXV) begin
      return MAXV[VAL_W-1:0];
    end else if (sh < MINV) begin
      return MINV[VAL_W-1:0];
    end
    return sh[VAL_W-1:0];
  endfunction

  bpt_div #(
    .NW        (NW),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk (clk),
    .en  (en),
    .n   (n),
    .k_u (head.row),
    .k_v (head.col),
    .t_u (t_u),
    .t_v (t_v)
  );

  for (genvar j = 0; j < ST; j++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        dly[j] <= (j == 0) ? head : dly[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (en) begin
        vld[j] <= (j == 0) ? !q_empty : vld[(j == 0) ? 0 : j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_item <= dly[ST-1];
      wu     <= weights(t_u);
      wv     <= weights(t_v);
      m_meta <= w_item.meta;
      m_wv   <= wv;
      for (int g = 0; g < 3; g++) begin
        prod[3*g]   <= mul(w_item.cp[3*g],   wu[3*TW-1:2*TW]);
        prod[3*g+1] <= mul(w_item.cp[3*g+1], wu[2*TW-1:TW]);
        prod[3*g+2] <= mul(w_item.cp[3*g+2], wu[TW-1:0]);
      end
      a_meta <= m_meta;
      a_wv   <= m_wv;
      for (int g = 0; g < 3; g++) begin
        tmp[g] <= blend_sum(prod[3*g], prod[3*g+1], prod[3*g+2]);
      end
      p_meta   <= a_meta;
      prod2[0] <= mul(tmp[0], a_wv[3*TW-1:2*TW]);
      prod2[1] <= mul(tmp[1], a_wv[2*TW-1:TW]);
      prod2[2] <= mul(tmp[2], a_wv[TW-1:0]);
      meta     <= p_meta;
      value    <= p_meta.range_error ? '0 : blend_sum(prod2[0], prod2[1], prod2[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_vld   <= 1'b0;
      m_vld   <= 1'b0;
      a_vld   <= 1'b0;
      p_vld   <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      w_vld   <= vld[ST-1];
      m_vld   <= w_vld;
      a_vld   <= m_vld;
      p_vld   <= a_vld;
      out_vld <= p_vld;
    end
  end

endmodule

// ===== src/biquadratic_patch_tessellator.sv =====
// biquadratic patch tessellator top level: configuration register, front end and back end
// an accepted item passes the divider stages, then the weight, product, blend, product and result registers
// throughput: one item per cycle while no result waits unclaimed, set by the bit-per-stage divider pipeline for u and v
// a four-entry queue sits between front and back; the back stalls only on a full result
// reset: subdivisions returns to 8, queue, pipeline and result register are emptied
module biquadratic_patch_tessellator import bpt_pkg::*; #(
  parameter int MAX_SUBDIV = MAX_SUBDIV_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     push,
  output logic                     full,
  input  logic signed [VAL_W-1:0]  cp0,
  input  logic signed [VAL_W-1:0]  cp1,
  input  logic signed [VAL_W-1:0]  cp2,
  input  logic signed [VAL_W-1:0]  cp3,
  input  logic signed [VAL_W-1:0]  cp4,
  input  logic signed [VAL_W-1:0]  cp5,
  input  logic signed [VAL_W-1:0]  cp6,
  input  logic signed [VAL_W-1:0]  cp7,
  input  logic signed [VAL_W-1:0]  cp8,
  input  logic [GRID_W-1:0]        grid_row,
  input  logic [GRID_W-1:0]        grid_col,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [VAL_W-1:0]  value,
  output logic [IDX_W-1:0]         vertex_index,
  output logic [IDX_W-1:0]         strip_even_index,
  output logic [IDX_W-1:0]         strip_odd_index,
  output logic                     strip_valid,
  output logic                     range_error
);

  localparam int NW = $clog2(MAX_SUBDIV + 1);
  localparam int CW = ((SUB_W > NW) ? SUB_W : NW) + 1;

  logic [SUB_W-1:0]             subdivisions;
  logic [NW-1:0]                n;
  logic [NUM_CP-1:0][VAL_W-1:0] cp;
  logic                         q_pop;
  logic                         q_empty;
  item_t                        head;
  meta_t                        meta;
  logic [VAL_W-1:0]             value_raw;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1:2] == REG_SUBDIV);
  assign prdata  = reg_sel ? DATA_W'(subdivisions) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      subdivisions <= SUBDIV_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      subdivisions <= pwdata[SUB_W-1:0];
    end
  end

  // effective segment count: zero reads as one, clamp at the maximum
  always_comb begin
    priority if (subdivisions == '0) begin
      n = NW'(1);
    end else if (CW'(subdivisions) > CW'(MAX_SUBDIV)) begin
      n = NW'(MAX_SUBDIV);
    end else begin
      n = NW'(subdivisions);
    end
  end

  assign cp = {cp8, cp7, cp6, cp5, cp4, cp3, cp2, cp1, cp0};

  bpt_front #(
    .NW (NW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .n       (n),
    .push    (push),
    .full    (full),
    .cp      (cp),
    .row     (grid_row),
    .col     (grid_col),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .head    (head)
  );

  bpt_back #(
    .NW        (NW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .n       (n),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .value   (value_raw),
    .meta    (meta)
  );

  assign value            = $signed(value_raw);
  assign vertex_index     = meta.vertex_index;
  assign strip_even_index = meta.strip_even_index;
  assign strip_odd_index  = meta.strip_odd_index;
  assign strip_valid      = meta.strip_valid;
  assign range_error      = meta.range_error;

endmodule
